// File: hw/rtl/quadratic_root_solver_assert.svh
// Assertion macros used by the checker file.
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// Same-cycle implication, sampled on clk and ignored while arst_n is low.
`define QRS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and ignored while arst_n is low.
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/qrs_pkg.sv
package qrs_pkg;
	localparam int COEF_W    = 16;
	localparam int FRAC_BITS = 16;
	localparam int D_W       = 34;
	localparam int VAL_W     = 48;
	localparam int NB_W      = COEF_W + FRAC_BITS + 1;
	localparam int DEN_W     = COEF_W + 2;
	localparam int DV_W      = DEN_W - 1;
	localparam int ROOT_W    = 32 + FRAC_BITS;
	localparam int REM_W     = ROOT_W + 2;
	localparam int N_W       = D_W;
	localparam int SQ_STEPS  = ROOT_W;
	localparam int NUM_W     = 36;
	localparam int MAG_W     = NUM_W - 1;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = 2;
	localparam int IN_W      = 3 * COEF_W;
	localparam int OUT_W     = 136;

	typedef enum logic [1:0] {
		KIND_TWO_REAL = 2'd0,
		KIND_DOUBLE   = 2'd1,
		KIND_COMPLEX  = 2'd2,
		KIND_A_ZERO   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                   kind;
		logic signed [D_W-1:0]   d;
		logic signed [NB_W-1:0]  nb;
		logic signed [DEN_W-1:0] den;
	} front_item_t;

	typedef struct packed {
		kind_t                 kind;
		logic signed [D_W-1:0] d;
	} div_meta_t;
endpackage

// File: hw/rtl/qrs_front.sv
module qrs_front import qrs_pkg::*; (
	input  logic                     in_valid,
	input  logic signed [COEF_W-1:0] coef_a,
	input  logic signed [COEF_W-1:0] coef_b,
	input  logic signed [COEF_W-1:0] coef_c,
	input  logic                     q_ready,
	output logic                     in_ready,
	output logic                     push,
	output front_item_t              item
);
	logic signed [2*COEF_W-1:0] prod_bb;
	logic signed [2*COEF_W-1:0] prod_ac;
	logic signed [D_W-1:0]      bb_x;
	logic signed [D_W-1:0]      ac_x;
	logic signed [NB_W-1:0]     b_x;

	always_comb begin
		prod_bb = coef_b * coef_b;
		prod_ac = coef_a * coef_c;
		bb_x = D_W'(prod_bb);
		ac_x = D_W'(prod_ac);
		b_x = NB_W'(coef_b);
		item.d = bb_x - (ac_x <<< 2);
		item.nb = -(b_x <<< FRAC_BITS);
		item.den = DEN_W'(coef_a) <<< 1;
		if (coef_a == '0) begin
			item.kind = KIND_A_ZERO;
		end else if (item.d[D_W-1]) begin
			item.kind = KIND_COMPLEX;
		end else if (item.d == '0) begin
			item.kind = KIND_DOUBLE;
		end else begin
			item.kind = KIND_TWO_REAL;
		end
	end

	assign in_ready = q_ready;
	assign push = in_valid && q_ready;
endmodule

// File: hw/rtl/qrs_queue.sv
module qrs_queue import qrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  front_item_t push_item,
	input  logic        pop,
	output logic        in_ready,
	output logic        out_valid,
	output front_item_t out_item
);
	front_item_t       mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign in_ready = cnt_q != (QPTR_W+1)'(QDEPTH);
	assign out_valid = cnt_q != '0;
	assign out_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end
endmodule

// File: hw/rtl/qrs_sqrt.sv
module qrs_sqrt import qrs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  front_item_t       in_item,
	output logic              out_valid,
	output front_item_t       out_item,
	output logic [ROOT_W-1:0] out_root
);
	logic              vld_s  [SQ_STEPS+1];
	front_item_t       item_s [SQ_STEPS+1];
	logic [N_W-1:0]    n_s    [SQ_STEPS+1];
	logic [REM_W-1:0]  rem_s  [SQ_STEPS+1];
	logic [ROOT_W-1:0] root_s [SQ_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[0] <= 1'b0;
		else if (en) vld_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s[0] <= in_item;
			n_s[0] <= in_item.d[D_W-1] ? N_W'(-in_item.d) : N_W'(in_item.d);
			rem_s[0] <= '0;
			root_s[0] <= '0;
		end
	end

	// Each stage brings down one radicand bit pair, most significant first.
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		localparam int I  = SQ_STEPS - 1 - k;
		localparam int SH = 2 * (I - FRAC_BITS);
		logic [1:0]       pair;
		logic [REM_W-1:0] rem_sh;
		logic [REM_W-1:0] trial;
		logic             ge;

		if (I >= FRAC_BITS && SH + 1 < N_W) begin : g_pair
			assign pair = n_s[k][SH+1:SH];
		end else begin : g_zero
			assign pair = 2'b00;
		end

		assign rem_sh = {rem_s[k][REM_W-3:0], pair};
		assign trial = {root_s[k], 2'b01};
		assign ge = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k+1] <= 1'b0;
			else if (en) vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				item_s[k+1] <= item_s[k];
				n_s[k+1] <= n_s[k];
				rem_s[k+1] <= ge ? rem_sh - trial : rem_sh;
				root_s[k+1] <= {root_s[k][ROOT_W-2:0], ge};
			end
		end
	end

	assign out_valid = vld_s[SQ_STEPS];
	assign out_item = item_s[SQ_STEPS];
	assign out_root = root_s[SQ_STEPS];
endmodule

// File: hw/rtl/qrs_div.sv
module qrs_div import qrs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  div_meta_t               in_meta,
	input  logic signed [NUM_W-1:0] num1,
	input  logic signed [NUM_W-1:0] num2,
	input  logic signed [DEN_W-1:0] den,
	output logic                    out_valid,
	output div_meta_t               out_meta,
	output logic [MAG_W-1:0]        quot1,
	output logic [MAG_W-1:0]        quot2,
	output logic                    neg1,
	output logic                    neg2
);
	logic             vld_s  [MAG_W+1];
	div_meta_t        meta_s [MAG_W+1];
	logic [DV_W-1:0]  dv_s   [MAG_W+1];
	logic [DV_W-1:0]  r1_s   [MAG_W+1];
	logic [DV_W-1:0]  r2_s   [MAG_W+1];
	logic [MAG_W-1:0] q1_s   [MAG_W+1];
	logic [MAG_W-1:0] q2_s   [MAG_W+1];
	logic             n1_s   [MAG_W+1];
	logic             n2_s   [MAG_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[0] <= 1'b0;
		else if (en) vld_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s[0] <= in_meta;
			dv_s[0] <= den[DEN_W-1] ? DV_W'(-den) : DV_W'(den);
			r1_s[0] <= '0;
			r2_s[0] <= '0;
			q1_s[0] <= num1[NUM_W-1] ? MAG_W'(-num1) : MAG_W'(num1);
			q2_s[0] <= num2[NUM_W-1] ? MAG_W'(-num2) : MAG_W'(num2);
			n1_s[0] <= num1[NUM_W-1] ^ den[DEN_W-1];
			n2_s[0] <= num2[NUM_W-1] ^ den[DEN_W-1];
		end
	end

	// Restoring division on magnitudes, one quotient bit per stage for both numerators.
	for (genvar k = 0; k < MAG_W; k++) begin : g_step
		logic [DV_W:0] rs1;
		logic [DV_W:0] rs2;
		logic          ge1;
		logic          ge2;

		assign rs1 = {r1_s[k], q1_s[k][MAG_W-1]};
		assign rs2 = {r2_s[k], q2_s[k][MAG_W-1]};
		assign ge1 = rs1 >= {1'b0, dv_s[k]};
		assign ge2 = rs2 >= {1'b0, dv_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k+1] <= 1'b0;
			else if (en) vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				meta_s[k+1] <= meta_s[k];
				dv_s[k+1] <= dv_s[k];
				n1_s[k+1] <= n1_s[k];
				n2_s[k+1] <= n2_s[k];
				r1_s[k+1] <= ge1 ? DV_W'(rs1 - {1'b0, dv_s[k]}) : rs1[DV_W-1:0];
				r2_s[k+1] <= ge2 ? DV_W'(rs2 - {1'b0, dv_s[k]}) : rs2[DV_W-1:0];
				q1_s[k+1] <= {q1_s[k][MAG_W-2:0], ge1};
				q2_s[k+1] <= {q2_s[k][MAG_W-2:0], ge2};
			end
		end
	end

	assign out_valid = vld_s[MAG_W];
	assign out_meta = meta_s[MAG_W];
	assign quot1 = q1_s[MAG_W];
	assign quot2 = q2_s[MAG_W];
	assign neg1 = n1_s[MAG_W];
	assign neg2 = n2_s[MAG_W];
endmodule

// File: hw/rtl/qrs_back.sv
module qrs_back import qrs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  front_item_t      q_item,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] out_data
);
	logic                    en;
	logic                    sq_valid;
	front_item_t             sq_item;
	logic [ROOT_W-1:0]       sq_root;
	logic signed [NUM_W-1:0] nb_x;
	logic signed [NUM_W-1:0] s_x;
	logic signed [NUM_W-1:0] num1;
	logic signed [NUM_W-1:0] num2;
	div_meta_t               meta;
	logic                    dv_valid;
	div_meta_t               dv_meta;
	logic [MAG_W-1:0]        quot1;
	logic [MAG_W-1:0]        quot2;
	logic                    neg1;
	logic                    neg2;
	logic signed [VAL_W-1:0] m1;
	logic signed [VAL_W-1:0] m2;
	logic signed [VAL_W-1:0] first;
	logic signed [VAL_W-1:0] second;
	logic                    out_valid_q;
	logic [OUT_W-1:0]        out_data_q;

	// The whole back end advances together unless a finished item is held.
	assign en = !out_valid_q || out_ready;
	assign q_pop = q_valid && en;

	qrs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (q_valid),
		.in_item  (q_item),
		.out_valid(sq_valid),
		.out_item (sq_item),
		.out_root (sq_root)
	);

	always_comb begin
		nb_x = NUM_W'(sq_item.nb);
		s_x = $signed(NUM_W'(sq_root));
		meta.kind = sq_item.kind;
		meta.d = sq_item.d;
		unique case (sq_item.kind)
			KIND_TWO_REAL: begin
				num1 = nb_x + s_x;
				num2 = nb_x - s_x;
			end
			KIND_DOUBLE: begin
				num1 = nb_x;
				num2 = nb_x;
			end
			KIND_COMPLEX: begin
				num1 = nb_x;
				num2 = s_x;
			end
			default: begin
				num1 = '0;
				num2 = '0;
			end
		endcase
	end

	qrs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sq_valid),
		.in_meta  (meta),
		.num1     (num1),
		.num2     (num2),
		.den      (sq_item.den),
		.out_valid(dv_valid),
		.out_meta (dv_meta),
		.quot1    (quot1),
		.quot2    (quot2),
		.neg1     (neg1),
		.neg2     (neg2)
	);

	always_comb begin
		m1 = VAL_W'(quot1);
		m2 = VAL_W'(quot2);
		first = neg1 ? -m1 : m1;
		second = neg2 ? -m2 : m2;
		if (dv_meta.kind == KIND_A_ZERO) begin
			first = '0;
			second = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= dv_valid;
	end

	always_ff @(posedge clk) begin
		if (en) out_data_q <= OUT_W'({second, first, dv_meta.d, dv_meta.kind});
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;
endmodule

// File: hw/rtl/quadratic_root_solver.sv
// Quadratic root solver: each input item carries the coefficients a, b and c, and each
// result item gives the root kind, the exact discriminant b*b - 4ac, and two values in
// signed fixed point with 16 fraction bits (two real roots, the double root twice, or the
// real and imaginary parts of a complex pair; zeros when a is zero). One item is taken
// per clock cycle for as long as results are drained. With an empty queue an item passes
// from acceptance through the four-entry queue, the digit-by-digit square root pipeline,
// the restoring divider pipeline and the output register to its result.
module quadratic_root_solver import qrs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // coef_a, coef_b, coef_c
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata   // root_kind, discriminant, first_value,
	                                        // second_value, zero fill
);
	logic        push;
	front_item_t front_item;
	logic        q_ready;
	logic        q_valid;
	front_item_t q_item;
	logic        q_pop;

	qrs_front u_front (
		.in_valid(s_axis_tvalid),
		.coef_a  (s_axis_tdata[COEF_W-1:0]),
		.coef_b  (s_axis_tdata[2*COEF_W-1:COEF_W]),
		.coef_c  (s_axis_tdata[3*COEF_W-1:2*COEF_W]),
		.q_ready (q_ready),
		.in_ready(s_axis_tready),
		.push    (push),
		.item    (front_item)
	);

	qrs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(front_item),
		.pop      (q_pop),
		.in_ready (q_ready),
		.out_valid(q_valid),
		.out_item (q_item)
	);

	qrs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata)
	);
endmodule

// File: hw/rtl/qrs_checker.sv
`include "quadratic_root_solver_assert.svh"

module qrs_checker import qrs_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);
	logic [1:0]       kind;
	logic [D_W-1:0]   disc;
	logic [VAL_W-1:0] first;
	logic [VAL_W-1:0] second;
	logic             in_acc;
	logic             out_acc;
	logic             out_stall;
	logic [7:0]       inflight_q;

	assign kind = m_axis_tdata[1:0];
	assign disc = m_axis_tdata[D_W+1:2];
	assign first = m_axis_tdata[VAL_W+D_W+1:D_W+2];
	assign second = m_axis_tdata[2*VAL_W+D_W+1:VAL_W+D_W+2];
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign out_stall = m_axis_tvalid && !m_axis_tready;

	// Items accepted at the input whose results have not yet left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 8'(in_acc) - 8'(out_acc);
		end
	end

	`QRS_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "held result changed")
	`QRS_ASSERT_NOW(a_zero_a, m_axis_tvalid && kind == KIND_A_ZERO, first == '0 && second == '0, "a zero gave roots")
	`QRS_ASSERT_NOW(a_double, m_axis_tvalid && kind == KIND_DOUBLE, disc == '0 && first == second, "double root mismatch")
	`QRS_ASSERT_NOW(a_complex, m_axis_tvalid && kind == KIND_COMPLEX, disc[D_W-1], "complex needs negative discriminant")
	`QRS_ASSERT_NOW(a_no_spurious, m_axis_tvalid, inflight_q != '0, "result without an input item")
endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (.*);
